// File: rtl/core/tmb_pkg.sv
// Timer bank package: opcodes, sequencer states, slot evaluation flags.
// No dependencies; used by every other file of the timer bank but tmb_slot_store.
`default_nettype none

package tmb_pkg;

  localparam int SLOT_FIELD_W  = 4;
  localparam int RATE_FIELD_W  = 2;
  localparam int COUNT_FIELD_W = 16;
  localparam int OP_W          = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_DISARM = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Outcome of visiting one slot during a tick walk
  typedef struct packed {
    logic hit;          // armed and in the ticked rate group
    logic drop;         // count already zero: disarm silently
    logic expire;       // count reaches zero on this tick
    logic periodic;     // nonzero reload interval
    logic write_count;  // countdown changes
    logic clear_armed;  // slot leaves the armed set
  } eval_t;

endpackage

`default_nettype wire

// File: rtl/core/tmb_in_if.sv
// Input channel of the timer bank: valid/ready plus one operation item.
// Depends on tmb_pkg for field widths.
`default_nettype none

interface tmb_in_if;
  logic                                valid;
  logic                                ready;
  logic [tmb_pkg::OP_W-1:0]            opcode;
  logic [tmb_pkg::SLOT_FIELD_W-1:0]    slot_index;
  logic [tmb_pkg::RATE_FIELD_W-1:0]    rate_index;
  logic [tmb_pkg::COUNT_FIELD_W-1:0]   start_count;
  logic [tmb_pkg::COUNT_FIELD_W-1:0]   reload_interval;

  modport source (output valid, opcode, slot_index, rate_index, start_count,
                  reload_interval, input ready);
  modport sink   (input valid, opcode, slot_index, rate_index, start_count,
                  reload_interval, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tmb_out_if.sv
// Output channel of the timer bank: valid/ready plus one expiry item.
// Depends on tmb_pkg for field widths.
`default_nettype none

interface tmb_out_if;
  logic                             valid;
  logic                             ready;
  logic [tmb_pkg::SLOT_FIELD_W-1:0] expired_slot;
  logic                             was_periodic;
  logic                             last_expiry;

  modport source (output valid, expired_slot, was_periodic, last_expiry,
                  input ready);
  modport sink   (input valid, expired_slot, was_periodic, last_expiry,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/multi_rate_software_timer_bank.sv
// Timer bank with several tick rates: sequencer, result holding and output register.
// Depends on tmb_pkg, tmb_in_if, tmb_out_if, tmb_slot_store, tmb_slot_eval.
//
// Usage: in_ch carries one operation per item: arm a slot (count, interval,
// rate), disarm a slot, or tick one rate group. out_ch carries one item per
// expiry: slot index, whether it reloaded, and a flag on the last expiry of
// the tick. Arm and disarm give no output.
// A tick walks the slot table one slot per cycle, pausing while a held
// expiry waits for the output register to be taken, through the table RAM's
// single read port and the shared decrement/compare unit; in_ch stays not
// ready from the tick until the walk and its final flush are done.
// Expiries come out in ascending slot order; one expiry is held back until
// the next one (or the end of the walk) shows whether it is the last.
// When out_ch stalls the walk pauses on the slot that needs to emit; no
// item is lost. The output register lets the next operation be accepted
// while the final expiry of a tick still waits to be taken.
// Reset (synchronous, rst high) disarms all slots and empties the output;
// the count/interval RAM needs no clearing since data of unarmed slots is never used.
`default_nettype none

module multi_rate_software_timer_bank #(
  parameter int TIMER_SLOTS = 16,
  parameter int RATE_GROUPS = 4,
  parameter int COUNT_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  tmb_in_if.sink          in_ch,
  tmb_out_if.source       out_ch
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int IDX_W  = $clog2(TIMER_SLOTS + 1);
  localparam int RATE_W = tmb_pkg::RATE_FIELD_W;
  localparam int OUT_W  = tmb_pkg::SLOT_FIELD_W;

  tmb_pkg::state_t state, state_next;

  logic [IDX_W-1:0]  rd_idx;
  logic              ev_valid;
  logic [SLOT_W-1:0] ev_idx;
  logic [RATE_W-1:0] tick_rate;
  logic              pend_valid;
  logic [OUT_W-1:0]  pend_slot;
  logic              pend_periodic;
  logic              out_valid;
  logic [OUT_W-1:0]  out_slot;
  logic              out_periodic;
  logic              out_last;

  logic              in_ready;
  logic              accept;
  logic              slot_ok;
  logic              rate_ok;
  logic [7:0]        slot_ext;
  logic [7:0]        ev_ext;
  logic [31:0]       start_ext;
  logic [31:0]       reload_ext;
  logic [SLOT_W-1:0] in_slot;
  logic              is_arm;
  logic              is_disarm;
  logic              is_tick;
  logic              can_emit;
  logic              emit_hit;
  logic              stall;
  logic              advance;
  logic              walk_done;
  logic              push_mid;
  logic              push_last;

  logic                  st_we;
  logic [SLOT_W-1:0]     st_waddr;
  logic [COUNT_BITS-1:0] st_wcount;
  logic [SLOT_W-1:0]     st_raddr;
  logic [COUNT_BITS-1:0] st_rcount;
  logic [COUNT_BITS-1:0] st_rinterval;
  logic [RATE_W-1:0]     st_rrate;
  logic                  st_clr_en;
  logic [SLOT_W-1:0]     st_clr_addr;
  logic                  st_armed;

  tmb_pkg::eval_t        ev;
  logic [COUNT_BITS-1:0] ev_new_count;

  // input decode, walk control and slot store control
  always_comb begin
    in_ready   = (state == tmb_pkg::ST_IDLE);
    accept     = in_ch.valid && in_ready;
    slot_ext   = 8'(in_ch.slot_index);
    ev_ext     = 8'(ev_idx);
    start_ext  = 32'(in_ch.start_count);
    reload_ext = 32'(in_ch.reload_interval);
    in_slot    = slot_ext[SLOT_W-1:0];
    slot_ok    = 32'(in_ch.slot_index) < TIMER_SLOTS;
    rate_ok    = 32'(in_ch.rate_index) < RATE_GROUPS;

    is_arm    = 1'b0;
    is_disarm = 1'b0;
    is_tick   = 1'b0;
    if (accept) begin
      case (in_ch.opcode)
        tmb_pkg::OP_ARM:    is_arm    = slot_ok && rate_ok;
        tmb_pkg::OP_DISARM: is_disarm = slot_ok;
        tmb_pkg::OP_TICK:   is_tick   = rate_ok;
        default: ;
      endcase
    end

    can_emit  = !out_valid || out_ch.ready;
    emit_hit  = ev_valid && ev.expire;
    // a second expiry cannot proceed while the held one has nowhere to go
    stall     = emit_hit && pend_valid && !can_emit;
    advance   = ev_valid && !stall;
    walk_done = (state == tmb_pkg::ST_WALK) && (rd_idx == IDX_W'(TIMER_SLOTS)) && !stall;
    push_mid  = emit_hit && !stall && pend_valid;
    push_last = (state == tmb_pkg::ST_FLUSH) && pend_valid && can_emit;

    st_we       = is_arm || (advance && ev.write_count);
    st_waddr    = is_arm ? in_slot : ev_idx;
    st_wcount   = is_arm ? start_ext[COUNT_BITS-1:0] : ev_new_count;
    // on a stall re-read the slot under evaluation so its data stays put
    st_raddr    = stall ? ev_idx : rd_idx[SLOT_W-1:0];
    st_clr_en   = is_disarm || (advance && ev.clear_armed);
    st_clr_addr = is_disarm ? in_slot : ev_idx;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmb_pkg::ST_IDLE:  if (is_tick) state_next = tmb_pkg::ST_WALK;
      tmb_pkg::ST_WALK:  if (walk_done) state_next = tmb_pkg::ST_FLUSH;
      tmb_pkg::ST_FLUSH: if (!pend_valid || can_emit) state_next = tmb_pkg::ST_IDLE;
      default:           state_next = tmb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tmb_pkg::ST_IDLE;
      rd_idx     <= '0;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (is_tick) begin
        rd_idx   <= '0;
        ev_valid <= 1'b0;
      end else if (state == tmb_pkg::ST_WALK && !stall) begin
        if (rd_idx != IDX_W'(TIMER_SLOTS)) begin
          ev_valid <= 1'b1;
          rd_idx   <= IDX_W'(rd_idx + 1'b1);
        end else begin
          ev_valid <= 1'b0;
        end
      end

      if (emit_hit && !stall) begin
        pend_valid <= 1'b1;
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end

      if (push_mid || push_last) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) tick_rate <= in_ch.rate_index;
    if (state == tmb_pkg::ST_WALK && !stall) ev_idx <= rd_idx[SLOT_W-1:0];
    if (emit_hit && !stall) begin
      pend_slot     <= ev_ext[OUT_W-1:0];
      pend_periodic <= ev.periodic;
    end
    if (push_mid || push_last) begin
      out_slot     <= pend_slot;
      out_periodic <= pend_periodic;
      out_last     <= push_last;
    end
  end

  tmb_slot_store #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .COUNT_BITS  (COUNT_BITS),
    .RATE_BITS   (RATE_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .we        (st_we),
    .we_full   (is_arm),
    .waddr     (st_waddr),
    .wcount    (st_wcount),
    .winterval (reload_ext[COUNT_BITS-1:0]),
    .wrate     (in_ch.rate_index),
    .raddr     (st_raddr),
    .rcount    (st_rcount),
    .rinterval (st_rinterval),
    .rrate     (st_rrate),
    .clr_en    (st_clr_en),
    .clr_addr  (st_clr_addr),
    .chk_addr  (ev_idx),
    .armed_bit (st_armed)
  );

  tmb_slot_eval #(
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .armed      (st_armed),
    .rate_match (st_rrate == tick_rate),
    .count      (st_rcount),
    .interval   (st_rinterval),
    .ev         (ev),
    .new_count  (ev_new_count)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.expired_slot = out_slot;
  assign out_ch.was_periodic = out_periodic;
  assign out_ch.last_expiry  = out_last;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == tmb_pkg::ST_IDLE) |-> !pend_valid)
    else $error("held expiry left over after tick walk");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    push_last |=> (state == tmb_pkg::ST_IDLE) && out_valid && out_last)
    else $error("final expiry did not close the tick");

  a_stall_holds_slot: assert property (@(posedge clk) disable iff (rst)
    stall |=> ev_valid && (ev_idx == $past(ev_idx)) && (state == tmb_pkg::ST_WALK))
    else $error("walk moved past a stalled expiry");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tmb_slot_store.sv
// Slot table of the timer bank: count/interval/rate RAM with registered read,
// plus armed flags in flops. No package dependencies.
`default_nettype none

module tmb_slot_store #(
  parameter int TIMER_SLOTS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int RATE_BITS   = 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   we,
  input  logic                                   we_full,
  input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] waddr,
  input  logic [COUNT_BITS-1:0]                  wcount,
  input  logic [COUNT_BITS-1:0]                  winterval,
  input  logic [RATE_BITS-1:0]                   wrate,
  input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] raddr,
  output logic [COUNT_BITS-1:0]                  rcount,
  output logic [COUNT_BITS-1:0]                  rinterval,
  output logic [RATE_BITS-1:0]                   rrate,
  input  logic                                   clr_en,
  input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] clr_addr,
  input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] chk_addr,
  output logic                                   armed_bit
);

  logic [COUNT_BITS-1:0] count_mem    [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] interval_mem [TIMER_SLOTS];
  logic [RATE_BITS-1:0]  rate_mem     [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] armed;

  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[waddr] <= wcount;
      if (we_full) begin
        interval_mem[waddr] <= winterval;
        rate_mem[waddr]     <= wrate;
      end
    end
    rcount    <= count_mem[raddr];
    rinterval <= interval_mem[raddr];
    rrate     <= rate_mem[raddr];
  end

  // arm sets through the full write; clears come from disarm or the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else begin
      if (we && we_full) armed[waddr] <= 1'b1;
      if (clr_en) armed[clr_addr] <= 1'b0;
    end
  end

  assign armed_bit = armed[chk_addr];

endmodule

`default_nettype wire

// File: rtl/core/tmb_slot_eval.sv
// Shared decrement/compare unit: decides what happens to one visited slot.
// Depends on tmb_pkg (eval_t).
`default_nettype none

module tmb_slot_eval #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  armed,
  input  logic                  rate_match,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [COUNT_BITS-1:0] interval,
  output tmb_pkg::eval_t        ev,
  output logic [COUNT_BITS-1:0] new_count
);

  logic [COUNT_BITS-1:0] dec;
  logic                  hit;
  logic                  is_zero;
  logic                  reaches_zero;
  logic                  periodic;

  always_comb begin
    dec          = count - COUNT_BITS'(1);
    hit          = armed && rate_match;
    is_zero      = (count == '0);
    reaches_zero = !is_zero && (dec == '0);
    periodic     = (interval != '0);

    ev.hit         = hit;
    ev.drop        = hit && is_zero;
    ev.expire      = hit && reaches_zero;
    ev.periodic    = periodic;
    ev.write_count = hit && !is_zero;
    ev.clear_armed = hit && (is_zero || (reaches_zero && !periodic));

    new_count = (reaches_zero && periodic) ? interval : dec;
  end

endmodule

`default_nettype wire
